// ----- src/twpg_pkg.sv -----
// twpg_pkg: shared types, constants and tables for the text window pixel generator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package twpg_pkg;

  localparam int TEXT_DEPTH    = 256;
  localparam int GLYPH_COUNT   = 96;
  localparam int GLYPH_COLUMNS = 16;
  localparam int GLYPH_DEPTH   = GLYPH_COUNT * GLYPH_COLUMNS;
  localparam int GLYPH_ROWS    = 16;
  localparam int TEXT_AW       = $clog2(TEXT_DEPTH);
  localparam int GLYPH_AW      = $clog2(GLYPH_DEPTH);
  localparam int ROW_AW        = $clog2(GLYPH_ROWS);

  localparam logic [7:0] FIRST_PRINTABLE = 8'd32;

  // reciprocal divide: q = (x * ceil(2^16 / d)) >> 16 is exact for x < 1024, d < 32
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = RECIP_W + 10;

  localparam logic [RECIP_W-1:0] RECIP_TAB [32] = '{
    17'd0,     17'd65536, 17'd32768, 17'd21846, 17'd16384, 17'd13108, 17'd10923, 17'd9363,
    17'd8192,  17'd7282,  17'd6554,  17'd5958,  17'd5462,  17'd5042,  17'd4682,  17'd4370,
    17'd4096,  17'd3856,  17'd3641,  17'd3450,  17'd3277,  17'd3121,  17'd2979,  17'd2850,
    17'd2731,  17'd2622,  17'd2521,  17'd2428,  17'd2341,  17'd2260,  17'd2185,  17'd2115
  };

  typedef enum logic [1:0] {
    ACT_CHAR  = 2'd0,
    ACT_GLYPH = 2'd1,
    ACT_PIXEL = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    CFG_INNER_WIDTH  = 3'd0,
    CFG_FONT_WIDTH   = 3'd1,
    CFG_FONT_HEIGHT  = 3'd2,
    CFG_TEXT_LENGTH  = 3'd3,
    CFG_TEXT_COLOR   = 3'd4,
    CFG_BG_COLOR     = 3'd5,
    CFG_SCROLL_LINES = 3'd6,
    CFG_CLIP_LINES   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [9:0]  inner_width;
    logic [4:0]  font_width;
    logic [4:0]  font_height;
    logic [8:0]  text_length;
    logic [15:0] text_color;
    logic [15:0] bg_color;
    logic [7:0]  scroll_lines;
    logic        clip_lines;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    inner_width:  10'd240,
    font_width:   5'd5,
    font_height:  5'd8,
    text_length:  9'd0,
    text_color:   16'hFFFF,
    bg_color:     16'h0000,
    scroll_lines: 8'd0,
    clip_lines:   1'b0
  };

  typedef struct packed {
    action_e     action;
    logic [7:0]  char_index;
    logic [7:0]  char_code;
    logic [6:0]  glyph_symbol;
    logic [3:0]  glyph_column;
    logic [15:0] glyph_bits;
    logic [9:0]  pixel_row;
    logic [9:0]  pixel_col;
  } item_t;

  // leaves the cell mapping pipe
  typedef struct packed {
    item_t              item;
    logic               blank;
    logic [TEXT_AW-1:0] text_addr;
    logic [4:0]         gcol;
    logic [4:0]         grow;
  } cell_t;

  // leaves the text store stage
  typedef struct packed {
    item_t      item;
    logic       blank;
    logic [7:0] code;
    logic [4:0] gcol;
    logic [4:0] grow;
  } code_t;

endpackage

// ----- src/twpg_ifs.sv -----
// twpg_in_if and twpg_out_if: valid/ready channels for requests and result pixels
// no dependencies
`timescale 1ns / 1ps

interface twpg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  char_index;
  logic [7:0]  char_code;
  logic [6:0]  glyph_symbol;
  logic [3:0]  glyph_column;
  logic [15:0] glyph_bits;
  logic [9:0]  pixel_row;
  logic [9:0]  pixel_col;

  modport source (
    output valid, action, char_index, char_code, glyph_symbol, glyph_column,
           glyph_bits, pixel_row, pixel_col,
    input  ready
  );
  modport sink (
    input  valid, action, char_index, char_code, glyph_symbol, glyph_column,
           glyph_bits, pixel_row, pixel_col,
    output ready
  );
endinterface

interface twpg_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_color;

  modport source (output valid, pixel_color, input ready);
  modport sink (input valid, pixel_color, output ready);
endinterface

// ----- src/twpg_cell_map.sv -----
// twpg_cell_map: five-stage pipe from a request to a text store address
// depends on twpg_pkg and twpg_in_if
`timescale 1ns / 1ps

module twpg_cell_map import twpg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  twpg_in_if.sink request,
  output logic  cell_valid,
  input  logic  cell_ready,
  output cell_t cell_item
);

  typedef struct packed {
    item_t      item;
    logic [9:0] qc;
    logic [9:0] qr;
    logic [9:0] cpl;
    logic       blank;
  } quot_t;

  typedef struct packed {
    item_t       item;
    logic [9:0]  cell_no;
    logic [9:0]  cpl;
    logic [10:0] line;
    logic [4:0]  gcol;
    logic [4:0]  grow;
    logic        blank;
  } split_t;

  typedef struct packed {
    item_t       item;
    logic [9:0]  cell_no;
    logic [9:0]  cpl;
    logic [10:0] line;
    logic [20:0] prod;
    logic [4:0]  gcol;
    logic [4:0]  grow;
    logic        blank;
  } line_t;

  logic [5:1] v;
  logic [5:1] free;

  item_t  s1;
  quot_t  s2;
  split_t s3;
  line_t  s4;

  logic [RECIP_W-1:0] mw;
  logic [RECIP_W-1:0] mh;
  logic [PROD_W-1:0]  col_prod;
  logic [PROD_W-1:0]  row_prod;
  logic [PROD_W-1:0]  cpl_prod;
  logic [14:0]        col_back;
  logic [14:0]        row_back;
  logic [21:0]        idx;
  logic               text_cut;
  logic               clip_cut;
  logic               glyph_cut;

  always_comb begin
    free[5] = !v[5] || cell_ready;
    free[4] = !v[4] || free[5];
    free[3] = !v[3] || free[4];
    free[2] = !v[2] || free[3];
    free[1] = !v[1] || free[2];
  end

  assign request.ready = free[1];
  assign cell_valid    = v[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (free[1]) v[1] <= request.valid;
      if (free[2]) v[2] <= v[1];
      if (free[3]) v[3] <= v[2];
      if (free[4]) v[4] <= v[3];
      if (free[5]) v[5] <= v[4];
    end
  end

  // quotients by reciprocal multiply
  always_comb begin
    mw       = RECIP_TAB[cfg.font_width];
    mh       = RECIP_TAB[cfg.font_height];
    col_prod = PROD_W'(s1.pixel_col) * PROD_W'(mw);
    row_prod = PROD_W'(s1.pixel_row) * PROD_W'(mh);
    cpl_prod = PROD_W'(cfg.inner_width) * PROD_W'(mw);
  end

  // remainders
  always_comb begin
    col_back = 15'(s2.qc) * 15'(cfg.font_width);
    row_back = 15'(s2.qr) * 15'(cfg.font_height);
  end

  // text index and the blank checks of the last stage
  always_comb begin
    idx       = 22'(s4.cell_no) + 22'(s4.prod);
    text_cut  = (idx >= 22'(cfg.text_length)) || (idx >= 22'(TEXT_DEPTH));
    clip_cut  = 1'b0;
    if (cfg.clip_lines) begin
      if ({1'b0, cfg.text_length} > s4.cpl) begin
        clip_cut = s4.prod > 21'(cfg.text_length);
      end else begin
        clip_cut = s4.line != 11'd0;
      end
    end
    glyph_cut = (s4.gcol >= 5'(GLYPH_COLUMNS)) || (s4.grow >= 5'(GLYPH_ROWS));
  end

  always_ff @(posedge clk) begin
    if (free[1]) begin
      s1.action       <= action_e'(request.action);
      s1.char_index   <= request.char_index;
      s1.char_code    <= request.char_code;
      s1.glyph_symbol <= request.glyph_symbol;
      s1.glyph_column <= request.glyph_column;
      s1.glyph_bits   <= request.glyph_bits;
      s1.pixel_row    <= request.pixel_row;
      s1.pixel_col    <= request.pixel_col;
    end
    if (free[2]) begin
      s2.item  <= s1;
      s2.qc    <= col_prod[RECIP_SHIFT +: 10];
      s2.qr    <= row_prod[RECIP_SHIFT +: 10];
      s2.cpl   <= cpl_prod[RECIP_SHIFT +: 10];
      s2.blank <= (cfg.font_width == 5'd0) || (cfg.font_height == 5'd0);
    end
    if (free[3]) begin
      s3.item    <= s2.item;
      s3.cell_no <= s2.qc;
      s3.cpl     <= s2.cpl;
      s3.line    <= 11'(s2.qr) + 11'(cfg.scroll_lines);
      s3.gcol    <= 5'(s2.item.pixel_col - col_back[9:0]);
      s3.grow    <= 5'(s2.item.pixel_row - row_back[9:0]);
      s3.blank   <= s2.blank || (s2.qc >= s2.cpl);
    end
    if (free[4]) begin
      s4.item    <= s3.item;
      s4.cell_no <= s3.cell_no;
      s4.cpl     <= s3.cpl;
      s4.line    <= s3.line;
      s4.prod    <= 21'(s3.line) * 21'(s3.cpl);
      s4.gcol    <= s3.gcol;
      s4.grow    <= s3.grow;
      s4.blank   <= s3.blank;
    end
    if (free[5]) begin
      cell_item.item      <= s4.item;
      cell_item.text_addr <= idx[TEXT_AW-1:0];
      cell_item.gcol      <= s4.gcol;
      cell_item.grow      <= s4.grow;
      cell_item.blank     <= s4.blank || text_cut || clip_cut || glyph_cut;
    end
  end

endmodule

// ----- src/twpg_text_fetch.sv -----
// twpg_text_fetch: text store stage, writes characters and reads the code of a cell
// depends on twpg_pkg
`timescale 1ns / 1ps

module twpg_text_fetch import twpg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  cell_valid,
  output logic  cell_ready,
  input  cell_t cell_item,
  output logic  code_valid,
  input  logic  code_ready,
  output code_t code
);

  logic [7:0] text_mem [TEXT_DEPTH];

  logic               v;
  logic               free;
  logic               wen;
  logic [TEXT_AW-1:0] waddr;

  assign free       = !v || code_ready;
  assign cell_ready = free;
  assign code_valid = v;

  always_comb begin
    waddr = TEXT_AW'(cell_item.item.char_index);
    wen   = cell_valid && free && (cell_item.item.action == ACT_CHAR)
            && (13'(cell_item.item.char_index) < 13'(TEXT_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (free) begin
      v <= cell_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free) begin
      code.item  <= cell_item.item;
      code.blank <= cell_item.blank;
      code.gcol  <= cell_item.gcol;
      code.grow  <= cell_item.grow;
      code.code  <= text_mem[cell_item.text_addr];
    end
    if (wen) begin
      text_mem[waddr] <= cell_item.item.char_code;
    end
  end

endmodule

// ----- src/twpg_glyph_shade.sv -----
// twpg_glyph_shade: glyph store stage and the output colour register
// depends on twpg_pkg and twpg_out_if
`timescale 1ns / 1ps

module twpg_glyph_shade import twpg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  code_valid,
  output logic  code_ready,
  input  code_t code,
  twpg_out_if.source result
);

  logic [15:0] glyph_mem [GLYPH_DEPTH];

  logic v7;
  logic v8;
  logic free7;
  logic free8;

  logic              pix7;
  logic              blank7;
  logic [ROW_AW-1:0] grow7;
  logic [15:0]       bits7;

  logic [7:0]          sym;
  logic                sym_cut;
  logic [GLYPH_AW-1:0] raddr;
  logic [GLYPH_AW-1:0] waddr;
  logic                wen;
  logic [15:0]         color;

  assign free8        = !v8 || result.ready;
  assign free7        = !v7 || free8;
  assign code_ready   = free7;
  assign result.valid = v8;

  always_comb begin
    sym     = code.code - FIRST_PRINTABLE;
    sym_cut = (code.code < FIRST_PRINTABLE) || (9'(sym) >= 9'(GLYPH_COUNT));
    raddr   = GLYPH_AW'(32'(sym) * GLYPH_COLUMNS + 32'(code.gcol));
    waddr   = GLYPH_AW'(32'(code.item.glyph_symbol) * GLYPH_COLUMNS
                        + 32'(code.item.glyph_column));
    wen     = code_valid && free7 && (code.item.action == ACT_GLYPH)
              && (8'(code.item.glyph_symbol) < 8'(GLYPH_COUNT))
              && (5'(code.item.glyph_column) < 5'(GLYPH_COLUMNS));
    color   = (!blank7 && bits7[grow7]) ? cfg.text_color : cfg.bg_color;
  end

  // store requests leave here; only pixels reach the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else begin
      if (free7) v7 <= code_valid;
      if (free8) v8 <= v7 && pix7;
    end
  end

  always_ff @(posedge clk) begin
    if (free7) begin
      pix7   <= code.item.action == ACT_PIXEL;
      blank7 <= code.blank || sym_cut;
      grow7  <= code.grow[ROW_AW-1:0];
      bits7  <= glyph_mem[raddr];
    end
    if (wen) begin
      glyph_mem[waddr] <= code.item.glyph_bits;
    end
    if (free8) begin
      result.pixel_color <= color;
    end
  end

endmodule

// ----- src/text_window_pixel_generator.sv -----
// One request per clock, store or pixel alike, while no held result stalls the pipe.
// Pixel requests give one colour each; character and glyph stores give none. The
// pipeline is five stages of cell mapping (reciprocal multiply for the divisions by
// font size, remainders, line times characters per line, index checks), one stage
// for the text store and one for the glyph store, each with a read and a write port,
// then the output register. A stalled result holds the full stages behind it up to
// the first empty one. Both stores come up undefined and need no clearing after reset.
// text_window_pixel_generator: top level, configuration registers and the pipe
// depends on twpg_pkg, twpg_ifs, twpg_cell_map, twpg_text_fetch, twpg_glyph_shade
`timescale 1ns / 1ps

module text_window_pixel_generator import twpg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  twpg_in_if.sink     request,
  twpg_out_if.source  result,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t  cfg;
  logic  cell_valid;
  logic  cell_ready;
  cell_t cell_item;
  logic  code_valid;
  logic  code_ready;
  code_t code;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        CFG_INNER_WIDTH:  cfg.inner_width  <= cfg_data[9:0];
        CFG_FONT_WIDTH:   cfg.font_width   <= cfg_data[4:0];
        CFG_FONT_HEIGHT:  cfg.font_height  <= cfg_data[4:0];
        CFG_TEXT_LENGTH:  cfg.text_length  <= cfg_data[8:0];
        CFG_TEXT_COLOR:   cfg.text_color   <= cfg_data;
        CFG_BG_COLOR:     cfg.bg_color     <= cfg_data;
        CFG_SCROLL_LINES: cfg.scroll_lines <= cfg_data[7:0];
        CFG_CLIP_LINES:   cfg.clip_lines   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  twpg_cell_map u_cell_map (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .request    (request),
    .cell_valid (cell_valid),
    .cell_ready (cell_ready),
    .cell_item  (cell_item)
  );

  twpg_text_fetch u_text_fetch (
    .clk        (clk),
    .rst        (rst),
    .cell_valid (cell_valid),
    .cell_ready (cell_ready),
    .cell_item  (cell_item),
    .code_valid (code_valid),
    .code_ready (code_ready),
    .code       (code)
  );

  twpg_glyph_shade u_glyph_shade (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .code_valid (code_valid),
    .code_ready (code_ready),
    .code       (code),
    .result     (result)
  );

  // the pipe only refuses a request when everything up to a held result is full
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !request.ready |-> (result.valid && !result.ready && cell_valid && code_valid))
    else $error("request refused while the pipe has room");

  // a result can only leave once the text stage has passed something on
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(code_valid, 2))
    else $error("result appeared without an item from the text stage");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!result.valid && !cell_valid && !code_valid))
    else $error("pipe not empty after reset");

endmodule
